>>> design/rhht_pkg.sv
package rhht_pkg;

	// default geometry
	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;

	// field widths fixed by the item format
	localparam int KEY_W    = 64;
	localparam int VAL_IN_W = 32;
	localparam int VAL_OUT_W = 32;
	localparam int STATUS_W = 2;
	localparam int HASH_W   = 32;
	localparam int LIMIT_W  = 11;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 11'd819;
	// register index is paddr[2]
	localparam logic REG_LOAD_LIMIT = 1'b0;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_SET = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_NEW  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_FIND_RD,
		S_FIND,
		S_PLACE_RD,
		S_PLACE,
		S_DONE
	} state_t;

endpackage

>>> design/rhht_if.sv
interface rhht_req_if
	import rhht_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic signed [KEY_W-1:0] key;
	logic [VAL_IN_W-1:0] value;

	modport source (output valid, cmd, key, value, input ready);
	modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface rhht_rsp_if
	import rhht_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [VAL_OUT_W-1:0] value_out;

	modport source (output valid, status, value_out, input ready);
	modport sink   (input valid, status, value_out, output ready);
endinterface

>>> design/rhht_ram.sv
module rhht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/robin_hood_hash_table_unit.sv
// Robin Hood hash map over CAPACITY slots held in one single-port-write RAM. A get returns
// status OK with the stored value, or MISS. A set updates a present key (OK), inserts a new
// one (NEW), or is refused (FULL) when the entry count is above load_limit (APB register at
// byte address 0, reset 819) or every slot is used. One item at a time: req is ready only
// when the unit is idle, and a finished result sits in an output register until taken.
// Steps per item: accept, then the quotient, remainder and fold steps of reciprocal
// multiplication for the home slot (skipped when CAPACITY is a power of two), then issue of
// the first RAM read, then one cycle per slot probed, since the single registered RAM read
// port visits one slot a cycle. A set of a new key re-issues the read at the home slot, then
// probes a second time from there to place the entry, one cycle per slot. The done state
// hands the result to the output register once that is free. A set refused on load goes from
// acceptance straight to the done state. After reset the unit sweeps the RAM to mark every
// slot empty and does not accept items meanwhile; configuration writes are taken throughout.
module robin_hood_hash_table_unit
	import rhht_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rhht_req_if.sink          req,
	rhht_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	localparam int IW = $clog2(CAPACITY);           // slot index
	localparam int CW = $clog2(CAPACITY + 1);       // entry count
	localparam int MW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
	localparam logic [IW:0]   CAP_W = (IW + 1)'(CAPACITY);
	localparam logic [IW-1:0] LAST  = IW'(CAPACITY - 1);
	localparam logic [1:0]    HASH_LAST = 2'd2;
	// reciprocal of CAPACITY scaled by 2^RSH, rounded down; fits HASH_W+1 bits
	localparam int RSH = HASH_W + IW;
	localparam logic [HASH_W:0]   RECIP = (HASH_W + 1)'((64'd1 << RSH) / 64'(CAPACITY));
	localparam logic [HASH_W-1:0] CAP_H = HASH_W'(CAPACITY);

	// one RAM word per slot; home is kept so the probe distance needs no modulo
	typedef struct packed {
		logic                  used;
		logic [IW-1:0]         home;
		logic [KEY_W-1:0]      key;
		logic [VALUE_BITS-1:0] value;
	} slot_t;

	localparam int SW = $bits(slot_t);

	state_t state_q, state_d;

	// control
	logic [IW-1:0]        pos_q, pos_d;
	logic [CW-1:0]        count_q, count_d;
	logic [LIMIT_W-1:0]   limit_q;
	logic                 ovalid_q;

	// working payload
	logic [IW:0]           dist_q, dist_d;
	logic [IW-1:0]         home_q, home_d;
	logic [IW:0]           hrem_q, hrem_d;
	logic [HASH_W-1:0]     hsh_q, hsh_d;
	logic [HASH_W-1:0]     hquo_q, hquo_d;
	logic [1:0]            hcnt_q, hcnt_d;
	cmd_t                  cmd_q, cmd_d;
	logic [KEY_W-1:0]      ckey_q, ckey_d;
	logic [VALUE_BITS-1:0] cval_q, cval_d;
	logic [IW-1:0]         chome_q, chome_d;
	status_t               res_status_q, res_status_d;
	logic [VAL_OUT_W-1:0]  res_value_q, res_value_d;
	logic [STATUS_W-1:0]   ostatus_q;
	logic [VAL_OUT_W-1:0]  ovalue_q;

	// RAM port
	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [SW-1:0] ram_wdata, ram_rdata;
	slot_t         rd, wr;

	// helpers
	logic              accept, out_free, load_out, apb_wr;
	logic              over_limit, table_full, key_hit, probe_stop;
	logic [IW:0]       ent_dist;
	logic [IW-1:0]     pos_next, hash_rem;
	logic [2*HASH_W:0] hprod;
	logic [HASH_W-1:0] hquo, hdiff;
	logic [63:0]       in_val64, rd_val64;

	rhht_ram #(
		.WIDTH (SW),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd        = slot_t'(ram_rdata);
	assign ram_wdata = SW'(wr);

	// ---------------------------------------------------------------- handshakes
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !ovalid_q || rsp.ready;
	assign load_out  = (state_q == S_DONE) && out_free;

	assign rsp.valid     = ovalid_q;
	assign rsp.status    = ostatus_q;
	assign rsp.value_out = ovalue_q;

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_LOAD_LIMIT) ? CFG_DW'(limit_q) : '0;

	// ---------------------------------------------------------------- shared datapath
	// probe distance of the stored entry: (pos - home) mod CAPACITY
	assign ent_dist = (pos_q >= rd.home) ? ({1'b0, pos_q} - {1'b0, rd.home})
	                                     : ({1'b0, pos_q} + CAP_W - {1'b0, rd.home});
	assign pos_next = (pos_q == LAST) ? '0 : pos_q + 1'b1;
	assign key_hit  = (rd.key == ckey_q);
	// lookup ends without a match: empty slot, richer entry, or whole ring seen
	assign probe_stop = (dist_q == CAP_W) || !rd.used || (ent_dist < dist_q);

	assign over_limit = MW'(count_q) > MW'(limit_q);
	assign table_full = count_q >= CW'(CAPACITY);

	// hash mod CAPACITY by reciprocal: the quotient undershoots by at most one, so the
	// remainder lands below 2*CAPACITY and a single subtraction folds it into range
	assign hprod    = (2*HASH_W+1)'(hsh_q) * (2*HASH_W+1)'(RECIP);
	assign hquo     = HASH_W'(hprod >> RSH);
	assign hdiff    = hsh_q - hquo_q * CAP_H;
	assign hash_rem = (hrem_q >= CAP_W) ? IW'(hrem_q - CAP_W) : IW'(hrem_q);

	assign in_val64 = 64'(req.value);
	assign rd_val64 = 64'(rd.value);

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (pos_q == LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_SET && over_limit) state_d = S_DONE;
					else if (IS_POW2)                     state_d = S_FIND_RD;
					else                                  state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (hcnt_q == HASH_LAST) state_d = S_FIND_RD;
			end
			S_FIND_RD: state_d = S_FIND;
			S_FIND: begin
				if (probe_stop) begin
					if (cmd_q == CMD_SET && !table_full) state_d = S_PLACE_RD;
					else                                 state_d = S_DONE;
				end else if (key_hit) begin
					state_d = S_DONE;
				end
			end
			S_PLACE_RD: state_d = S_PLACE;
			S_PLACE: begin
				if (!rd.used) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- sequencer outputs
	always_comb begin
		pos_d        = pos_q;
		count_d      = count_q;
		dist_d       = dist_q;
		home_d       = home_q;
		hrem_d       = hrem_q;
		hsh_d        = hsh_q;
		hquo_d       = hquo_q;
		hcnt_d       = hcnt_q;
		cmd_d        = cmd_q;
		ckey_d       = ckey_q;
		cval_d       = cval_q;
		chome_d      = chome_q;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		ram_we       = 1'b0;
		ram_waddr    = pos_q;
		ram_raddr    = pos_q;
		wr           = '0;

		case (state_q)
			S_CLEAR: begin
				// mark every slot empty
				ram_we = 1'b1;
				pos_d  = pos_next;
			end
			S_IDLE: begin
				if (accept) begin
					cmd_d        = cmd_t'(req.cmd);
					ckey_d       = req.key;
					cval_d       = in_val64[VALUE_BITS-1:0];
					res_status_d = ST_FULL;
					res_value_d  = '0;
					dist_d       = '0;
					hrem_d       = '0;
					hcnt_d       = '0;
					hsh_d        = req.key[HASH_W-1:0];
					if (IS_POW2) begin
						home_d = req.key[IW-1:0];
						pos_d  = req.key[IW-1:0];
					end
				end
			end
			S_HASH: begin
				// quotient, then remainder, then fold; each step reads the one before
				hquo_d = hquo;
				hrem_d = (IW + 1)'(hdiff);
				hcnt_d = hcnt_q + 1'b1;
				home_d = hash_rem;
				pos_d  = hash_rem;
			end
			S_FIND_RD: begin
				// read of pos_q issued by default
			end
			S_FIND: begin
				if (probe_stop) begin
					res_status_d = (cmd_q == CMD_GET) ? ST_MISS
					             : (table_full ? ST_FULL : ST_NEW);
					// placement restarts at the home slot
					pos_d   = home_q;
					dist_d  = '0;
					chome_d = home_q;
				end else if (key_hit) begin
					res_status_d = ST_OK;
					if (cmd_q == CMD_GET) begin
						res_value_d = rd_val64[VAL_OUT_W-1:0];
					end else begin
						// update in place
						wr       = rd;
						wr.value = cval_q;
						ram_we   = 1'b1;
					end
				end else begin
					pos_d     = pos_next;
					dist_d    = dist_q + 1'b1;
					ram_raddr = pos_next;
				end
			end
			S_PLACE_RD: begin
			end
			S_PLACE: begin
				wr.used  = 1'b1;
				wr.home  = chome_q;
				wr.key   = ckey_q;
				wr.value = cval_q;
				if (!rd.used) begin
					ram_we  = 1'b1;
					count_d = count_q + 1'b1;
				end else begin
					pos_d     = pos_next;
					ram_raddr = pos_next;
					if (ent_dist < dist_q) begin
						// richer entry gives up its slot and travels on
						ram_we  = 1'b1;
						ckey_d  = rd.key;
						cval_d  = rd.value;
						chome_d = rd.home;
						dist_d  = ent_dist + 1'b1;
					end else begin
						dist_d = dist_q + 1'b1;
					end
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			pos_q    <= '0;
			count_q  <= '0;
			limit_q  <= LOAD_LIMIT_RST;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			count_q <= count_d;
			if (apb_wr && paddr[2] == REG_LOAD_LIMIT) begin
				limit_q <= pwdata[LIMIT_W-1:0];
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		dist_q       <= dist_d;
		home_q       <= home_d;
		hrem_q       <= hrem_d;
		hsh_q        <= hsh_d;
		hquo_q       <= hquo_d;
		hcnt_q       <= hcnt_d;
		cmd_q        <= cmd_d;
		ckey_q       <= ckey_d;
		cval_q       <= cval_d;
		chome_q      <= chome_d;
		res_status_q <= res_status_d;
		res_value_q  <= res_value_d;
		if (load_out) begin
			ostatus_q <= res_status_q;
			ovalue_q  <= res_value_q;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_only_on_place: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_PLACE))
		else $error("entry count changed outside placement");

	a_value_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.value_out == '0))
		else $error("non-zero value on a result other than found");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> (count_q == '0))
		else $error("entry count moved during clearing pass");
`endif

endmodule
